@@ hdl/anchsim_pkg.sv @@
package anchsim_pkg;

   // sizing
   localparam int ANCHORS = 16;
   localparam int MAX_DIM = 64;
   localparam int IDX_W = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // field widths
   localparam int CMD_W = 2;
   localparam int SLOT_W = 4;
   localparam int ESLOT_W = 6;
   localparam int SAMPLE_W = 16;
   localparam int NUM_W = 4;
   localparam int SCORE_W = 48;
   localparam int PSUM_W = 41;
   localparam int TERM_W = 34;

   // configuration register widths and indexes
   localparam int MODE_W = 1;
   localparam int LEN_W = 7;
   localparam int CNT_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEC_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_COUNT = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_VALUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END = 2'd2;

   // score modes
   localparam logic MODE_DOT = 1'b0;
   localparam logic MODE_DIST = 1'b1;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   // cycles for the last value element to settle in the last cell
   localparam int DRAIN_CYCLES = ANCHORS + 6;
   localparam int DRAIN_W = $clog2(DRAIN_CYCLES + 1);

   // item handed from cell to cell
   typedef struct packed {
      logic                       valid;
      logic                       load;
      logic [SLOT_W-1:0]          anchor_slot;
      logic [DIM_W-1:0]           addr;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       close;
      logic                       mode;
   } chain_item_type;

endpackage

@@ hdl/anchsim_cell.sv @@
module anchsim_cell
   import anchsim_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [IDX_W-1:0]           cell_index,
   input  logic                       clear,
   input  chain_item_type             item_in,
   output chain_item_type             item_out,
   output logic signed [SCORE_W-1:0]  best_score
);

   // anchor vector of this cell
   logic signed [SAMPLE_W-1:0] anchor_mem [MAX_DIM];

   chain_item_type item_ff;

   logic signed [SAMPLE_W-1:0] anchor_rd_ff;
   logic signed [SAMPLE_W-1:0] sample1_ff;
   logic v1_ff, close1_ff, mode1_ff;

   logic signed [SAMPLE_W:0] diff;
   logic signed [SAMPLE_W:0] op_a_in, op_b_in, op_a_ff, op_b_ff;
   logic v2_ff, close2_ff, mode2_ff;

   logic signed [TERM_W-1:0] term_ff;
   logic v3_ff, close3_ff, mode3_ff;

   logic signed [PSUM_W-1:0] psum_ff, psum_in, sum;
   logic signed [PSUM_W-1:0] closed_ff;
   logic v4_ff, mode4_ff;

   logic signed [SCORE_W-1:0] cand, best_ff, best_in;
   logic write_hit;

   // item register, forwarded to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end
   assign item_out = item_ff;

   // anchor memory: load write, registered read
   assign write_hit = item_ff.valid && item_ff.load
                      && (32'(item_ff.anchor_slot) == 32'(cell_index));
   always_ff @(posedge clock) begin
      if (write_hit) begin
         anchor_mem[item_ff.addr] <= item_ff.sample;
      end
      anchor_rd_ff <= anchor_mem[item_ff.addr];
      sample1_ff <= item_ff.sample;
      close1_ff <= item_ff.close;
      mode1_ff <= item_ff.mode;
   end

   // operand select: product or difference squared
   always_comb begin
      diff = (SAMPLE_W+1)'(anchor_rd_ff) - (SAMPLE_W+1)'(sample1_ff);
      if (mode1_ff == MODE_DIST) begin
         op_a_in = diff;
         op_b_in = diff;
      end else begin
         op_a_in = (SAMPLE_W+1)'(anchor_rd_ff);
         op_b_in = (SAMPLE_W+1)'(sample1_ff);
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      close2_ff <= close1_ff;
      mode2_ff <= mode1_ff;
      term_ff <= op_a_ff * op_b_ff;
      close3_ff <= close2_ff;
      mode3_ff <= mode2_ff;
   end

   // accumulate; a closing element hands the sum on and restarts
   assign sum = psum_ff + PSUM_W'(term_ff);
   always_comb begin
      psum_in = psum_ff;
      if (v3_ff) begin
         psum_in = close3_ff ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      closed_ff <= sum;
      mode4_ff <= mode3_ff;
   end

   // keep the best closed vector score
   always_comb begin
      cand = (mode4_ff == MODE_DIST) ? -SCORE_W'(closed_ff) : SCORE_W'(closed_ff);
      best_in = best_ff;
      if (v4_ff && (cand > best_ff)) begin
         best_in = cand;
      end
   end

   // control and running state
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         psum_ff <= '0;
         best_ff <= SCORE_MIN;
      end else begin
         v1_ff <= item_ff.valid && !item_ff.load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff && close3_ff;
         psum_ff <= psum_in;
         best_ff <= best_in;
      end
   end

   assign best_score = best_ff;

endmodule

@@ hdl/anchor_sequence_similarity.sv @@
// Channel   Dir  Ports                   Contents
// request   in   req_tvalid/tready/tdata  tuser = command
// response  out  rsp_tvalid/tready/tdata  tlast = last
// csr       in   csr_we/index/wdata       score_mode, vector size, anchor_count
//
// Load and value elements are taken one per cycle while req_tready is high; each
// passes the row of ANCHORS cells one cell a cycle, five stages per cell to the best
// score. An end of example drains the row, then loads one score a cycle into the
// output register while rsp_tready allows. Reset is synchronous and clears running
// state, not anchor memory. req_tready is low from end of example until the final
// score is loaded.
module anchor_sequence_similarity
   import anchsim_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // anchor_slot, element_slot, sample
   input  logic [CMD_W-1:0]      req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,  // anchor_number, score
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [MODE_W-1:0] mode_ff;
   logic [LEN_W-1:0] len_ff;
   logic [CNT_W-1:0] count_ff;

   logic [1:0] state_ff, state_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic [IDX_W-1:0] emit_ff, emit_in;
   logic [DIM_W-1:0] pos_ff, pos_in;

   logic [SLOT_W-1:0] in_slot;
   logic [ESLOT_W-1:0] in_eslot;
   logic signed [SAMPLE_W-1:0] in_sample;
   logic accept;

   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] pos_cl;
   logic [IDX_W-1:0] last_idx;
   logic clear;
   logic load_out;

   chain_item_type head_item;
   chain_item_type chain [ANCHORS+1];
   logic signed [SCORE_W-1:0] best [ANCHORS];

   logic rsp_valid_ff;
   logic [NUM_W-1:0] num_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic last_ff;

   assign in_slot = req_tdata[3:0];
   assign in_eslot = req_tdata[9:4];
   assign in_sample = req_tdata[25:10];
   assign req_tready = (state_ff == ST_RUN);
   assign accept = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DOT;
         len_ff <= LEN_W'(1);
         count_ff <= CNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCORE_MODE:    mode_ff <= csr_wdata[0];
            CSR_VEC_SIZE:      len_ff <= csr_wdata[LEN_W-1:0];
            CSR_ANCHOR_COUNT:  count_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective length, clamped position and last anchor index
   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(len_ff) > MAX_DIM) begin
         len_eff = LEN_W'(MAX_DIM);
      end else begin
         len_eff = len_ff;
      end
      pos_cl = (LEN_W'(pos_ff) >= len_eff) ? len_eff - LEN_W'(1) : LEN_W'(pos_ff);
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (32'(count_ff) > ANCHORS) begin
         last_idx = IDX_W'(ANCHORS - 1);
      end else begin
         last_idx = IDX_W'(count_ff - CNT_W'(1));
      end
   end

   // item entering the first cell
   always_comb begin
      head_item = '0;
      head_item.anchor_slot = in_slot;
      head_item.sample = in_sample;
      head_item.mode = mode_ff;
      head_item.close = (pos_cl + LEN_W'(1)) >= len_eff;
      if (accept && req_tuser == CMD_LOAD) begin
         head_item.valid = (32'(in_eslot) < MAX_DIM);
         head_item.load = 1'b1;
         head_item.addr = DIM_W'(in_eslot);
      end else begin
         head_item.valid = accept && (req_tuser == CMD_VALUE);
         head_item.load = 1'b0;
         head_item.addr = DIM_W'(pos_cl);
      end
   end

   assign load_out = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign clear = load_out && (emit_ff == last_idx);

   // sequencer: run, drain, emit
   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff;
      emit_in = emit_ff;
      pos_in = pos_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (accept && req_tuser == CMD_VALUE) begin
               pos_in = head_item.close ? '0 : DIM_W'(pos_cl + LEN_W'(1));
            end
            if (accept && req_tuser == CMD_END) begin
               state_in = ST_DRAIN;
               drain_in = DRAIN_W'(DRAIN_CYCLES);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - DRAIN_W'(1);
            if (drain_ff == '0) begin
               state_in = ST_EMIT;
               emit_in = '0;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               emit_in = emit_ff + IDX_W'(1);
               if (clear) begin
                  state_in = ST_RUN;
                  pos_in = '0;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         drain_ff <= '0;
         emit_ff <= '0;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
         emit_ff <= emit_in;
         pos_ff <= pos_in;
      end
   end

   // row of cells, one per anchor
   assign chain[0] = head_item;
   for (genvar i = 0; i < ANCHORS; i++) begin : g_cell
      anchsim_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .clear      (clear),
         .item_in    (chain[i]),
         .item_out   (chain[i+1]),
         .best_score (best[i])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         num_ff <= NUM_W'(emit_ff);
         score_ff <= best[emit_ff];
         last_ff <= (emit_ff == last_idx);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0000, score_ff, num_ff};
   assign rsp_tlast = last_ff;

endmodule
